// ===== hw/rtl/gpstu_pkg.sv =====
package gpstu_pkg;

    localparam int LEAP_N = 18;

    localparam logic [11:0] LEAP_YEAR [LEAP_N] = '{
        12'd2017, 12'd2015, 12'd2012, 12'd2009, 12'd2006, 12'd1999,
        12'd1997, 12'd1996, 12'd1994, 12'd1993, 12'd1992, 12'd1991,
        12'd1990, 12'd1988, 12'd1985, 12'd1983, 12'd1982, 12'd1981
    };
    localparam logic [3:0] LEAP_MONTH [LEAP_N] = '{
        4'd1, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1, 4'd7,
        4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7
    };
    localparam logic [4:0] LEAP_COUNT [LEAP_N] = '{
        5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10,
        5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1
    };

    // floor(30.6001 * n) for n = 0..31
    localparam logic [9:0] MTERM_TAB [32] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
        10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459,
        10'd489, 10'd520, 10'd550, 10'd581, 10'd612, 10'd642, 10'd673, 10'd703,
        10'd734, 10'd765, 10'd795, 10'd826, 10'd856, 10'd887, 10'd918, 10'd948
    };

    localparam int US_PER_S    = 1000000;
    localparam int S_PER_DAY   = 86400;
    localparam int S_PER_HOUR  = 3600;
    localparam int S_PER_MIN   = 60;
    localparam int JD_BIAS     = 1537;
    localparam int ALPHA_DIV   = 146097;
    localparam int ALPHA_SHIFT = 5;            // offset in multiples of ALPHA_DIV
    localparam int ALPHA_BASE  = 7468865 - ALPHA_SHIFT * ALPHA_DIV;
    localparam int C_DIV       = 7305;
    localparam int E_DIV       = 306001;

    // reciprocal constants floor(2^k / divisor)
    localparam int RCP_US   = 67;    // k = 26
    localparam int RCP_HOUR = 36;    // k = 17
    localparam int RCP_MIN  = 68;    // k = 12
    localparam int RCP_ALPH = 57;    // k = 23
    localparam int RCP_C    = 9186;  // k = 26
    localparam int RCP_E    = 109;   // k = 25

endpackage

// ===== hw/rtl/gpst_utc_date_conversion_core.sv =====
// Channel  Handshake             Word
// in       in_valid / in_ready   kind, in_year .. in_second_us
// out      out_valid / out_ready out_year .. out_second_us, leap_applied
//
// Thirteen register stages; one word enters per cycle while the pipe advances.
// Depth is set by the chain of reciprocal divisions of the date back conversion.
// Reset clears only the stage valid bits.
// The whole pipe advances when the output register is empty or taken;
// in_ready follows that advance, so a stall holds every stage.
module gpst_utc_date_conversion_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [11:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [4:0]  in_day,
    input  logic [4:0]  in_hour,
    input  logic [5:0]  in_minute,
    input  logic [25:0] in_second_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [25:0] out_second_us,
    output logic [4:0]  leap_applied
);

    logic        adv;
    logic [13:1] vld_reg;

    assign adv       = !vld_reg[13] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[13];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[12:1], in_valid};
    end

    // ---------------- stage 1: leap lookup, day-count product
    logic [20:0] key;
    logic [4:0]  leap_c;
    logic        early;
    logic [13:0] ysum;
    logic [4:0]  midx;
    logic [32:0] s0_prod;

    always_comb
    begin
        key    = {in_year, in_month, in_day};
        leap_c = '0;
        for (int i = gpstu_pkg::LEAP_N - 1; i >= 0; i--)
        begin
            if (key >= {gpstu_pkg::LEAP_YEAR[i], gpstu_pkg::LEAP_MONTH[i], 5'd1})
                leap_c = gpstu_pkg::LEAP_COUNT[i];
        end
        early   = (in_month <= 4'd2);
        ysum    = {2'b0, in_year} + (early ? 14'd4715 : 14'd4716);
        midx    = early ? ({1'b0, in_month} + 5'd13) : ({1'b0, in_month} + 5'd1);
        s0_prod = {7'b0, in_second_us} * 33'(gpstu_pkg::RCP_US);
    end

    logic        s1_kind_reg;
    logic [4:0]  s1_leap_reg;
    logic [24:0] s1_proda_reg;
    logic [9:0]  s1_mterm_reg;
    logic [4:0]  s1_day_reg;
    logic [4:0]  s1_hour_reg;
    logic [5:0]  s1_min_reg;
    logic [25:0] s1_sus_reg;
    logic [6:0]  s1_s0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg  <= kind;
            s1_leap_reg  <= leap_c;
            s1_proda_reg <= {11'b0, ysum} * 25'd1461;
            s1_mterm_reg <= gpstu_pkg::MTERM_TAB[midx];
            s1_day_reg   <= in_day;
            s1_hour_reg  <= in_hour;
            s1_min_reg   <= in_minute;
            s1_sus_reg   <= in_second_us;
            s1_s0_reg    <= s0_prod[32:26];
        end
    end

    // ---------------- stage 2: day number, split seconds
    logic [22:0] jd_sum;
    logic [26:0] sur;
    logic        s_fix;

    always_comb
    begin
        jd_sum = 23'(s1_proda_reg[24:2]) + 23'(s1_mterm_reg) + 23'(s1_day_reg)
               - 23'(gpstu_pkg::JD_BIAS);
        sur    = {1'b0, s1_sus_reg} - {20'b0, s1_s0_reg} * 27'(gpstu_pkg::US_PER_S);
        s_fix  = (sur >= 27'(gpstu_pkg::US_PER_S));
    end

    logic        s2_kind_reg;
    logic [4:0]  s2_leap_reg;
    logic [21:0] s2_jd_reg;
    logic [6:0]  s2_s_reg;
    logic [19:0] s2_us_reg;
    logic [16:0] s2_hm_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_leap_reg <= s1_leap_reg;
            s2_jd_reg   <= jd_sum[21:0];
            s2_s_reg    <= s1_s0_reg + {6'b0, s_fix};
            s2_us_reg   <= s_fix ? 20'(sur - 27'(gpstu_pkg::US_PER_S)) : sur[19:0];
            s2_hm_reg   <= {12'b0, s1_hour_reg} * 17'(gpstu_pkg::S_PER_HOUR)
                         + {11'b0, s1_min_reg} * 17'(gpstu_pkg::S_PER_MIN);
        end
    end

    // ---------------- stage 3: apply leap seconds, day rollover
    logic signed [18:0] tsec;
    logic [16:0]        tod_c;
    logic [21:0]        jd2;
    logic [24:0]        xs;

    always_comb
    begin
        tsec = $signed({2'b0, s2_hm_reg}) + $signed({12'b0, s2_s_reg});
        if (s2_kind_reg)
            tsec = tsec + $signed({14'b0, s2_leap_reg});
        else
            tsec = tsec - $signed({14'b0, s2_leap_reg});
        if (tsec < 0)
        begin
            tod_c = 17'(tsec + 19'sd86400);
            jd2   = s2_jd_reg - 22'd1;
        end
        else if (tsec >= 19'(gpstu_pkg::S_PER_DAY))
        begin
            tod_c = 17'(tsec - 19'sd86400);
            jd2   = s2_jd_reg + 22'd1;
        end
        else
        begin
            tod_c = tsec[16:0];
            jd2   = s2_jd_reg;
        end
        xs = {1'b0, jd2, 2'b0} - 25'(gpstu_pkg::ALPHA_BASE);
    end

    logic [4:0]  s3_leap_reg;
    logic [21:0] s3_jd_reg;
    logic [22:0] s3_x_reg;
    logic [16:0] s3_tod_reg;
    logic [19:0] s3_us_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_leap_reg <= s2_leap_reg;
            s3_jd_reg   <= jd2;
            s3_x_reg    <= xs[22:0];
            s3_tod_reg  <= tod_c;
            s3_us_reg   <= s2_us_reg;
        end
    end

    // ---------------- stage 4: reciprocal estimates for alpha and hour
    logic [28:0] qprod;
    logic [22:0] hprod;

    assign qprod = {6'b0, s3_x_reg} * 29'(gpstu_pkg::RCP_ALPH);
    assign hprod = {6'b0, s3_tod_reg} * 23'(gpstu_pkg::RCP_HOUR);

    logic [4:0]  s4_leap_reg;
    logic [21:0] s4_jd_reg;
    logic [22:0] s4_x_reg;
    logic [5:0]  s4_q0_reg;
    logic [16:0] s4_tod_reg;
    logic [4:0]  s4_h0_reg;
    logic [19:0] s4_us_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_leap_reg <= s3_leap_reg;
            s4_jd_reg   <= s3_jd_reg;
            s4_x_reg    <= s3_x_reg;
            s4_q0_reg   <= qprod[28:23];
            s4_tod_reg  <= s3_tod_reg;
            s4_h0_reg   <= hprod[21:17];
            s4_us_reg   <= s3_us_reg;
        end
    end

    // ---------------- stage 5: correct alpha and hour
    logic [22:0] rq;
    logic [6:0]  q;
    logic [16:0] rh;
    logic        h_fix;

    always_comb
    begin
        rq    = s4_x_reg - 23'({17'b0, s4_q0_reg} * 23'(gpstu_pkg::ALPHA_DIV));
        q     = {1'b0, s4_q0_reg} + {6'b0, (rq >= 23'(gpstu_pkg::ALPHA_DIV))};
        rh    = s4_tod_reg - {12'b0, s4_h0_reg} * 17'(gpstu_pkg::S_PER_HOUR);
        h_fix = (rh >= 17'(gpstu_pkg::S_PER_HOUR));
    end

    logic [4:0]        s5_leap_reg;
    logic [21:0]       s5_jd_reg;
    logic signed [6:0] s5_alpha_reg;
    logic [4:0]        s5_hour_reg;
    logic [11:0]       s5_rmin_reg;
    logic [19:0]       s5_us_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_leap_reg  <= s4_leap_reg;
            s5_jd_reg    <= s4_jd_reg;
            s5_alpha_reg <= $signed(q - 7'(gpstu_pkg::ALPHA_SHIFT));
            s5_hour_reg  <= s4_h0_reg + {4'b0, h_fix};
            s5_rmin_reg  <= h_fix ? 12'(rh - 17'(gpstu_pkg::S_PER_HOUR)) : rh[11:0];
            s5_us_reg    <= s4_us_reg;
        end
    end

    // ---------------- stage 6: Gregorian correction, minute estimate
    logic signed [23:0] b_s;
    logic [26:0]        cx;
    logic [18:0]        mprod;

    always_comb
    begin
        b_s   = $signed({2'b0, s5_jd_reg}) + 24'sd1525 + 24'(s5_alpha_reg)
              - 24'(s5_alpha_reg >>> 2);
        cx    = {b_s[22:0], 4'b0} + {2'b0, b_s[22:0], 2'b0} - 27'd2442;
        mprod = {7'b0, s5_rmin_reg} * 19'(gpstu_pkg::RCP_MIN);
    end

    logic [4:0]  s6_leap_reg;
    logic [21:0] s6_b_reg;
    logic [25:0] s6_cx_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_rmin_reg;
    logic [5:0]  s6_m0_reg;
    logic [19:0] s6_us_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_leap_reg <= s5_leap_reg;
            s6_b_reg    <= b_s[21:0];
            s6_cx_reg   <= cx[25:0];
            s6_hour_reg <= s5_hour_reg;
            s6_rmin_reg <= s5_rmin_reg;
            s6_m0_reg   <= mprod[17:12];
            s6_us_reg   <= s5_us_reg;
        end
    end

    // ---------------- stage 7: year estimate, correct minute
    logic [39:0] cprod;
    logic [11:0] rs;
    logic        m_fix;

    always_comb
    begin
        cprod = {14'b0, s6_cx_reg} * 40'(gpstu_pkg::RCP_C);
        rs    = s6_rmin_reg - {6'b0, s6_m0_reg} * 12'(gpstu_pkg::S_PER_MIN);
        m_fix = (rs >= 12'(gpstu_pkg::S_PER_MIN));
    end

    logic [4:0]  s7_leap_reg;
    logic [21:0] s7_b_reg;
    logic [25:0] s7_cx_reg;
    logic [13:0] s7_c0_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    logic [19:0] s7_us_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_leap_reg <= s6_leap_reg;
            s7_b_reg    <= s6_b_reg;
            s7_cx_reg   <= s6_cx_reg;
            s7_c0_reg   <= cprod[39:26];
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s6_m0_reg + {5'b0, m_fix};
            s7_sec_reg  <= m_fix ? 6'(rs - 12'(gpstu_pkg::S_PER_MIN)) : rs[5:0];
            s7_us_reg   <= s6_us_reg;
        end
    end

    // ---------------- stage 8: correct year count, rebuild microseconds
    logic [25:0] rc;

    assign rc = s7_cx_reg - {12'b0, s7_c0_reg} * 26'(gpstu_pkg::C_DIV);

    logic [4:0]  s8_leap_reg;
    logic [21:0] s8_b_reg;
    logic [13:0] s8_c_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [25:0] s8_secus_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_leap_reg  <= s7_leap_reg;
            s8_b_reg     <= s7_b_reg;
            s8_c_reg     <= s7_c0_reg + {13'b0, (rc >= 26'(gpstu_pkg::C_DIV))};
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_secus_reg <= {20'b0, s7_sec_reg} * 26'(gpstu_pkg::US_PER_S)
                          + {6'b0, s7_us_reg};
        end
    end

    // ---------------- stage 9: day within the year count
    logic [24:0] dprod;
    logic [21:0] bd_full;

    always_comb
    begin
        dprod   = {11'b0, s8_c_reg} * 25'd1461;
        bd_full = s8_b_reg - {1'b0, dprod[22:2]};
    end

    logic [4:0]  s9_leap_reg;
    logic [10:0] s9_bd_reg;
    logic [13:0] s9_c_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [25:0] s9_secus_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_leap_reg  <= s8_leap_reg;
            s9_bd_reg    <= bd_full[10:0];
            s9_c_reg     <= s8_c_reg;
            s9_hour_reg  <= s8_hour_reg;
            s9_min_reg   <= s8_min_reg;
            s9_secus_reg <= s8_secus_reg;
        end
    end

    // ---------------- stage 10: scale for month estimate
    logic [4:0]  s10_leap_reg;
    logic [10:0] s10_bd_reg;
    logic [24:0] s10_ex_reg;
    logic [13:0] s10_c_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg;
    logic [25:0] s10_secus_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_leap_reg  <= s9_leap_reg;
            s10_bd_reg    <= s9_bd_reg;
            s10_ex_reg    <= {14'b0, s9_bd_reg} * 25'd10000;
            s10_c_reg     <= s9_c_reg;
            s10_hour_reg  <= s9_hour_reg;
            s10_min_reg   <= s9_min_reg;
            s10_secus_reg <= s9_secus_reg;
        end
    end

    // ---------------- stage 11: month estimate
    logic [31:0] eprod;

    assign eprod = {7'b0, s10_ex_reg} * 32'(gpstu_pkg::RCP_E);

    logic [4:0]  s11_leap_reg;
    logic [10:0] s11_bd_reg;
    logic [24:0] s11_ex_reg;
    logic [6:0]  s11_e0_reg;
    logic [13:0] s11_c_reg;
    logic [4:0]  s11_hour_reg;
    logic [5:0]  s11_min_reg;
    logic [25:0] s11_secus_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_leap_reg  <= s10_leap_reg;
            s11_bd_reg    <= s10_bd_reg;
            s11_ex_reg    <= s10_ex_reg;
            s11_e0_reg    <= eprod[31:25];
            s11_c_reg     <= s10_c_reg;
            s11_hour_reg  <= s10_hour_reg;
            s11_min_reg   <= s10_min_reg;
            s11_secus_reg <= s10_secus_reg;
        end
    end

    // ---------------- stage 12: correct month estimate
    logic [24:0] re;

    assign re = s11_ex_reg - {18'b0, s11_e0_reg} * 25'(gpstu_pkg::E_DIV);

    logic [4:0]  s12_leap_reg;
    logic [10:0] s12_bd_reg;
    logic [6:0]  s12_e_reg;
    logic [13:0] s12_c_reg;
    logic [4:0]  s12_hour_reg;
    logic [5:0]  s12_min_reg;
    logic [25:0] s12_secus_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s12_leap_reg  <= s11_leap_reg;
            s12_bd_reg    <= s11_bd_reg;
            s12_e_reg     <= s11_e0_reg + {6'b0, (re >= 25'(gpstu_pkg::E_DIV))};
            s12_c_reg     <= s11_c_reg;
            s12_hour_reg  <= s11_hour_reg;
            s12_min_reg   <= s11_min_reg;
            s12_secus_reg <= s11_secus_reg;
        end
    end

    // ---------------- stage 13: output word
    logic [10:0]       day_full;
    logic signed [7:0] month_full;
    logic [13:0]       year_full;

    always_comb
    begin
        day_full   = s12_bd_reg - {1'b0, gpstu_pkg::MTERM_TAB[s12_e_reg[4:0]]};
        month_full = (s12_e_reg < 7'd14) ? $signed({1'b0, s12_e_reg} - 8'd1)
                                         : $signed({1'b0, s12_e_reg} - 8'd13);
        year_full  = (month_full > 8'sd2) ? (s12_c_reg - 14'd4716)
                                          : (s12_c_reg - 14'd4715);
    end

    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_minute_reg;
    logic [25:0] out_second_us_reg;
    logic [4:0]  leap_applied_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_year_reg      <= year_full[11:0];
            out_month_reg     <= month_full[3:0];
            out_day_reg       <= day_full[4:0];
            out_hour_reg      <= s12_hour_reg;
            out_minute_reg    <= s12_min_reg;
            out_second_us_reg <= s12_secus_reg;
            leap_applied_reg  <= s12_leap_reg;
        end
    end

    assign out_year      = out_year_reg;
    assign out_month     = out_month_reg;
    assign out_day       = out_day_reg;
    assign out_hour      = out_hour_reg;
    assign out_minute    = out_minute_reg;
    assign out_second_us = out_second_us_reg;
    assign leap_applied  = leap_applied_reg;

endmodule

// ===== test/tb_gpst_utc_date_conversion_core.sv =====
module tb_gpst_utc_date_conversion_core;

    localparam longint US_DAY  = 64'd86400000000;
    localparam longint US_HOUR = 64'd3600000000;
    localparam longint US_MIN  = 64'd60000000;
    localparam int     LIMIT   = 400000;

    typedef struct packed {
        logic        kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [25:0] second_us;
    } stamp_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [25:0] second_us;
        logic [4:0]  leap;
    } conv_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [25:0] in_second_us;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [25:0] out_second_us;
    logic [4:0]  leap_applied;

    stamp_t pending_stamps[$];
    conv_t  expected_dates[$];
    int     errors;
    int     cycles;
    logic   in_taken;

    gpst_utc_date_conversion_core u_top (.*);

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [4:0] leap_count(stamp_t s);
        logic [20:0] key;
        logic [20:0] ref_key;
        key = {s.year, s.month, s.day};
        for (int i = 0; i < gpstu_pkg::LEAP_N; i++)
        begin
            ref_key = {gpstu_pkg::LEAP_YEAR[i], gpstu_pkg::LEAP_MONTH[i], 5'd1};
            if (key >= ref_key)
                return gpstu_pkg::LEAP_COUNT[i];
        end
        return 5'd0;
    endfunction

    function automatic conv_t convert_stamp(stamp_t s);
        conv_t  r;
        longint y, m, jd, days, t, rem, alpha, a, b, c, d, e, dd, mm, yy;
        r.leap = leap_count(s);
        y = longint'(s.year);
        m = longint'(s.month);
        if (m <= 2)
        begin
            y = y - 1;
            m = m + 12;
        end
        jd = floor_div(1461 * (y + 4716), 4) + floor_div(306001 * (m + 1), 10000)
           + longint'(s.day) - 1537;
        days = jd - 2400001 - 44244;
        t = days * US_DAY + longint'(s.hour) * US_HOUR + longint'(s.minute) * US_MIN
          + longint'(s.second_us);
        if (s.kind)
            t = t + longint'(r.leap) * 1000000;
        else
            t = t - longint'(r.leap) * 1000000;
        days = floor_div(t, US_DAY);
        rem = t - days * US_DAY;
        jd = days + 44244 + 2400001;
        alpha = floor_div(4 * jd - 7468865, 146097);
        a = jd + 1 + alpha - floor_div(alpha, 4);
        b = a + 1524;
        c = floor_div(20 * b - 2442, 7305);
        d = floor_div(1461 * c, 4);
        e = floor_div(10000 * (b - d), 306001);
        dd = b - d - floor_div(306001 * e, 10000);
        mm = (e < 14) ? (e - 1) : (e - 13);
        yy = (mm > 2) ? (c - 4716) : (c - 4715);
        r.year = yy[11:0];
        r.month = mm[3:0];
        r.day = dd[4:0];
        r.hour = 5'(rem / US_HOUR);
        rem = rem % US_HOUR;
        r.minute = 6'(rem / US_MIN);
        r.second_us = 26'(rem % US_MIN);
        return r;
    endfunction

    task automatic add_stamp(int k, int y, int mo, int d, int h, int mi, int su);
        stamp_t s;
        s.kind = 1'(k);
        s.year = 12'(y);
        s.month = 4'(mo);
        s.day = 5'(d);
        s.hour = 5'(h);
        s.minute = 6'(mi);
        s.second_us = 26'(su);
        pending_stamps.push_back(s);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        errors++;
    endtask

    function automatic bit idle_now();
        // no idling at all in a long early stretch
        if (cycles > 400 && cycles < 900)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= !idle_now();
            if (!in_valid || in_taken)
            begin
                if (pending_stamps.size() > 0 && !idle_now())
                begin
                    {kind, in_year, in_month, in_day, in_hour, in_minute, in_second_us}
                        <= pending_stamps.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        conv_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_dates.push_back(convert_stamp({kind, in_year, in_month, in_day,
                                                    in_hour, in_minute, in_second_us}));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
                report_mismatch("extra word", 1, 0);
            else
            begin
                want = expected_dates.pop_front();
                if (out_year != want.year)
                    report_mismatch("year", int'(out_year), int'(want.year));
                if (out_month != want.month)
                    report_mismatch("month", int'(out_month), int'(want.month));
                if (out_day != want.day)
                    report_mismatch("day", int'(out_day), int'(want.day));
                if (out_hour != want.hour)
                    report_mismatch("hour", int'(out_hour), int'(want.hour));
                if (out_minute != want.minute)
                    report_mismatch("minute", int'(out_minute), int'(want.minute));
                if (out_second_us != want.second_us)
                    report_mismatch("second_us", int'(out_second_us), int'(want.second_us));
                if (leap_applied != want.leap)
                    report_mismatch("leap", int'(leap_applied), int'(want.leap));
            end
        end
    end

    initial
    begin
        int y;
        int mo;
        int idx;
        errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {kind, in_year, in_month, in_day, in_hour, in_minute, in_second_us} = '0;

        // epoch, range ends, leap boundaries, rollover both ways, malformed fields
        add_stamp(0, 1980, 1, 6, 0, 0, 0);
        add_stamp(1, 1980, 1, 6, 0, 0, 0);
        add_stamp(0, 1980, 1, 1, 0, 0, 0);
        add_stamp(0, 2199, 12, 31, 23, 59, 59999999);
        add_stamp(1, 2199, 12, 31, 23, 59, 59999999);
        add_stamp(0, 1981, 6, 30, 23, 59, 59999999);
        add_stamp(0, 1981, 7, 1, 0, 0, 0);
        add_stamp(0, 2017, 1, 1, 0, 0, 5000000);
        add_stamp(1, 2016, 12, 31, 23, 59, 50000000);
        add_stamp(1, 2017, 1, 1, 0, 0, 0);
        add_stamp(0, 2015, 6, 31, 23, 59, 59999999);
        add_stamp(0, 2000, 2, 29, 12, 30, 30000000);
        add_stamp(1, 2100, 2, 29, 0, 0, 0);
        add_stamp(0, 2010, 0, 0, 0, 0, 0);
        add_stamp(1, 2010, 13, 1, 0, 0, 0);
        add_stamp(0, 2010, 15, 31, 31, 63, 67108863);
        add_stamp(1, 2017, 15, 31, 31, 63, 67108863);
        add_stamp(0, 0, 0, 0, 0, 0, 0);
        add_stamp(1, 4095, 15, 31, 31, 63, 67108863);
        add_stamp(0, 1999, 1, 0, 0, 0, 0);
        add_stamp(1, 2012, 7, 1, 0, 0, 0);

        for (int i = 0; i < 950; i++)
        begin
            if ($urandom_range(99) < 15)
                add_stamp($urandom_range(1), $urandom_range(4095), $urandom_range(15),
                          $urandom_range(31), $urandom_range(31), $urandom_range(63),
                          $urandom_range(67108863));
            else if ($urandom_range(99) < 30)
            begin
                // near a table entry, around midnight
                idx = $urandom_range(gpstu_pkg::LEAP_N - 1);
                y = int'(gpstu_pkg::LEAP_YEAR[idx]);
                mo = int'(gpstu_pkg::LEAP_MONTH[idx]);
                if ($urandom_range(1))
                    add_stamp($urandom_range(1), y, mo, 1, 0, 0, $urandom_range(20000000));
                else if (mo == 1)
                    add_stamp($urandom_range(1), y - 1, 12, 31, 23, 59,
                              $urandom_range(59999999, 40000000));
                else
                    add_stamp($urandom_range(1), y, 6, 30, 23, 59,
                              $urandom_range(59999999, 40000000));
            end
            else
                add_stamp($urandom_range(1), $urandom_range(2199, 1980),
                          $urandom_range(12, 1), $urandom_range(28, 1),
                          $urandom_range(23), $urandom_range(59),
                          $urandom_range(59999999));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_stamps.size() == 0 && !in_valid);
        wait (expected_dates.size() == 0);
        repeat (30) @(posedge clk);
        if (errors == 0 && expected_dates.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
